### rtl/vnt_pkg.sv
// Shared constants, types and command/status bundles of the value noise turbulence block.
`default_nettype none

package vnt_pkg;

    // Table geometry; both sides must be powers of two (index wrap is a mask).
    localparam int TABLE_COLS     = 256;
    localparam int TABLE_ROWS     = 256;
    localparam int MAX_OCTAVE_LOG = 8;

    localparam int COL_W  = $clog2(TABLE_COLS);
    localparam int ROW_W  = $clog2(TABLE_ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = TABLE_ROWS * TABLE_COLS;

    // Port field widths.
    localparam int COORD_W   = 24;
    localparam int ENTRY_W   = 8;
    localparam int SMP_W     = 15;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd5;

    // Fixed-point widths.
    localparam int FRAC_BASE = 8;                                 // fraction bits at octave 0
    localparam int FW        = FRAC_BASE + MAX_OCTAVE_LOG;        // widest fraction
    localparam int OCT_W     = (MAX_OCTAVE_LOG > 0) ? $clog2(MAX_OCTAVE_LOG + 1) : 1;
    localparam int SH_W      = $clog2(FW + 1);
    localparam int QSH_W     = $clog2(2 * MAX_OCTAVE_LOG + 2);
    localparam int OSH_W     = $clog2(SMP_W + MAX_OCTAVE_LOG + 1);
    localparam int AV_W      = FW + SMP_W;                        // row blend value
    localparam int MA_W      = AV_W + 1;                          // signed multiplicand
    localparam int MB_W      = FW + 1;                            // signed weight
    localparam int MP_W      = MA_W + MB_W;                       // product
    localparam int P_W       = 2 * FW + SMP_W;                    // full bilinear value
    localparam int Q_W       = 2 * FRAC_BASE + SMP_W - 1;         // Q0.30 octave sample
    localparam int TERM_W    = Q_W + MAX_OCTAVE_LOG;
    localparam int ACC_W     = TERM_W + 1;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // Corner samples of one cell: previous/current row, previous/current column.
    typedef enum logic [1:0] {
        TAP_PP = 2'd0,
        TAP_PC = 2'd1,
        TAP_CP = 2'd2,
        TAP_CC = 2'd3
    } t_tap;

    typedef enum logic [1:0] {
        MUL_ROW_PRV = 2'd0,
        MUL_ROW_CUR = 2'd1,
        MUL_COL     = 2'd2
    } t_mul;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_RD0  = 4'd1,
        ST_RD1  = 4'd2,
        ST_RD2  = 4'd3,
        ST_RD3  = 4'd4,
        ST_MA   = 4'd5,
        ST_MB   = 4'd6,
        ST_MC   = 4'd7,
        ST_MD   = 4'd8,
        ST_AC   = 4'd9,
        ST_FIN  = 4'd10,
        ST_DONE = 4'd11
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic rd_en;
        t_tap rd_sel;
        logic smp_load;
        t_tap smp_sel;
        logic mul_en;
        t_mul mul_sel;
        logic aprv_load;
        logic acur_load;
        logic term_load;
        logic j_step;
        logic acc_add;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_octave;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/vnt_dpath.sv
// Datapath: noise table, octave arithmetic, accumulator and result register.
`default_nettype none

module vnt_dpath
    import vnt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata,
    input  wire logic [COORD_W-1:0]  i_x_coord,
    input  wire logic [COORD_W-1:0]  i_y_coord,
    input  wire logic [ENTRY_W-1:0]  i_entry_row,
    input  wire logic [ENTRY_W-1:0]  i_entry_col,
    input  wire logic [SMP_W-1:0]    i_entry_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OUT_W-1:0]         o_turbulence_value
);

    logic [CFG_W-1:0]          r_cfg_oct;
    logic [COORD_W-1:0]        r_x;
    logic [COORD_W-1:0]        r_y;
    logic [OCT_W-1:0]          r_k;
    logic [OCT_W-1:0]          r_j;
    logic [SMP_W-1:0]          r_mem [DEPTH];
    logic [SMP_W-1:0]          r_rd;
    logic [SMP_W-1:0]          r_smp [4];
    logic signed [MP_W-1:0]    r_prod;
    logic [AV_W-1:0]           r_aprv;
    logic [AV_W-1:0]           r_acur;
    logic [TERM_W-1:0]         r_term;
    logic [ACC_W-1:0]          r_acc;
    logic [OUT_W-1:0]          r_out;
    logic                      r_out_valid;

    logic [OCT_W-1:0]          k_sat;
    logic [SH_W-1:0]           f_sh;
    logic [COORD_W-1:0]        f_mask;
    logic [FW-1:0]             fx;
    logic [FW-1:0]             fy;
    logic [COL_W-1:0]          cx;
    logic [COL_W-1:0]          px;
    logic [ROW_W-1:0]          cy;
    logic [ROW_W-1:0]          py;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         mem_addr;
    logic                      wr_ok;
    logic signed [SMP_W:0]     d_prv;
    logic signed [SMP_W:0]     d_cur;
    logic signed [AV_W:0]      d_col;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    sum_prv;
    logic signed [MP_W-1:0]    sum_cur;
    logic signed [MP_W-1:0]    sum_col;
    logic [P_W-1:0]            p_val;
    logic [QSH_W-1:0]          q_sh;
    logic [Q_W-1:0]            q_val;
    logic [OSH_W-1:0]          o_sh;

    // Saturate the octave register to the largest supported size.
    always_comb begin
        if (int'(r_cfg_oct) > MAX_OCTAVE_LOG) begin
            k_sat = OCT_W'(MAX_OCTAVE_LOG);
        end else begin
            k_sat = OCT_W'(r_cfg_oct);
        end
    end

    // Cell indices and fractions at the current octave.
    always_comb begin
        f_sh   = SH_W'(FRAC_BASE) + SH_W'(r_j);
        f_mask = (COORD_W'(1) << f_sh) - COORD_W'(1);
        fx     = FW'(r_x & f_mask);
        fy     = FW'(r_y & f_mask);
        cx     = COL_W'(r_x >> f_sh);
        cy     = ROW_W'(r_y >> f_sh);
        px     = cx - COL_W'(1);
        py     = cy - ROW_W'(1);
        case (i_cmd.rd_sel)
            TAP_PP:  rd_addr = {py, px};
            TAP_PC:  rd_addr = {py, cx};
            TAP_CP:  rd_addr = {cy, px};
            TAP_CC:  rd_addr = {cy, cx};
            default: rd_addr = {cy, cx};
        endcase
    end

    // Drop writes that fall outside the table.
    always_comb begin
        wr_ok    = i_cmd.wr_en && (int'(i_entry_row) < TABLE_ROWS)
                   && (int'(i_entry_col) < TABLE_COLS);
        wr_addr  = {ROW_W'(i_entry_row), COL_W'(i_entry_col)};
        mem_addr = wr_ok ? wr_addr : rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[mem_addr] <= i_entry_value;
        end else if (i_cmd.rd_en) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    // Lerp form: a = lo * 2^F + w * (hi - lo), exact for weights w and 2^F - w.
    always_comb begin
        d_prv = $signed({1'b0, r_smp[1]}) - $signed({1'b0, r_smp[0]});
        d_cur = $signed({1'b0, r_smp[3]}) - $signed({1'b0, r_smp[2]});
        d_col = $signed({1'b0, r_acur}) - $signed({1'b0, r_aprv});
        case (i_cmd.mul_sel)
            MUL_ROW_PRV: begin
                mul_a = MA_W'(d_prv);
                mul_b = $signed({1'b0, fx});
            end
            MUL_ROW_CUR: begin
                mul_a = MA_W'(d_cur);
                mul_b = $signed({1'b0, fx});
            end
            MUL_COL: begin
                mul_a = MA_W'(d_col);
                mul_b = $signed({1'b0, fy});
            end
            default: begin
                mul_a = MA_W'(d_col);
                mul_b = $signed({1'b0, fy});
            end
        endcase
        sum_prv = $signed(MP_W'(r_smp[0]) << f_sh) + r_prod;
        sum_cur = $signed(MP_W'(r_smp[2]) << f_sh) + r_prod;
        sum_col = $signed(MP_W'(r_aprv) << f_sh) + r_prod;
        p_val   = sum_col[P_W-1:0];
        q_sh    = QSH_W'(2 * r_j) + QSH_W'(1);
        q_val   = Q_W'(p_val >> q_sh);
        o_sh    = OSH_W'(SMP_W) + OSH_W'(r_k);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_x_coord;
            r_y <= i_y_coord;
            r_k <= k_sat;
        end
        if (i_cmd.smp_load) begin
            r_smp[i_cmd.smp_sel] <= r_rd;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.aprv_load) begin
            r_aprv <= sum_prv[AV_W-1:0];
        end
        if (i_cmd.acur_load) begin
            r_acur <= sum_cur[AV_W-1:0];
        end
        if (i_cmd.start) begin
            r_term <= '0;
            r_acc  <= '0;
        end else begin
            if (i_cmd.term_load) begin
                r_term <= TERM_W'(q_val) << r_j;
            end
            if (i_cmd.acc_add) begin
                r_acc <= r_acc + ACC_W'(r_term);
            end
        end
        if (i_cmd.out_load) begin
            r_out <= OUT_W'(r_acc >> o_sh);
        end
    end

    // Octave counter: runs from k down to zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_j <= k_sat;
        end else if (i_cmd.j_step && (r_j != '0)) begin
            r_j <= r_j - OCT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_oct   <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_oct <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.last_octave = (r_j == '0);
    assign o_stat.out_free    = !r_out_valid || i_ready;
    assign o_valid            = r_out_valid;
    assign o_turbulence_value = r_out;

endmodule

`default_nettype wire

### rtl/vnt_ctrl.sv
// Controller: sequences table writes and the per-octave read/multiply schedule.
`default_nettype none

module vnt_ctrl
    import vnt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_command,
    output logic            o_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_stat   i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (t_cmd'(i_command) == CMD_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_RD0;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_RD0: begin
                // fold in the previous octave's term
                o_cmd.acc_add = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_PP;
                n_state       = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = TAP_PC;
                o_cmd.smp_load = 1'b1;
                o_cmd.smp_sel  = TAP_PP;
                n_state        = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = TAP_CP;
                o_cmd.smp_load = 1'b1;
                o_cmd.smp_sel  = TAP_PC;
                n_state        = ST_RD3;
            end
            ST_RD3: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = TAP_CC;
                o_cmd.smp_load = 1'b1;
                o_cmd.smp_sel  = TAP_CP;
                n_state        = ST_MA;
            end
            ST_MA: begin
                o_cmd.smp_load = 1'b1;
                o_cmd.smp_sel  = TAP_CC;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_ROW_PRV;
                n_state        = ST_MB;
            end
            ST_MB: begin
                o_cmd.aprv_load = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_ROW_CUR;
                n_state         = ST_MC;
            end
            ST_MC: begin
                o_cmd.acur_load = 1'b1;
                n_state         = ST_MD;
            end
            ST_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_COL;
                n_state       = ST_AC;
            end
            ST_AC: begin
                o_cmd.term_load = 1'b1;
                o_cmd.j_step    = 1'b1;
                n_state         = i_stat.last_octave ? ST_FIN : ST_RD0;
            end
            ST_FIN: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/value_noise_turbulence_top.sv
// Top level of the value noise turbulence block: controller plus datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | i_valid / o_ready  | i_command, i_x_coord, i_y_coord, i_entry_row,
//           |                    | i_entry_col, i_entry_value
//  result   | o_valid / i_ready  | o_turbulence_value
//  config   | i_cfg_we           | i_cfg_wdata (octave_log2)
//
// A write transaction stores one table sample in the cycle it is accepted; the
// next transaction can follow in the next cycle.
// A query runs k+1 octave passes between acceptance and o_valid, k being the
// saturated octave_log2: each octave makes four reads on the single table port
// and three passes through one shared 32x17 multiplier. o_ready stays low
// while the query runs and rises in the same cycle as o_valid.
// A finished result waits in the output register; a new transaction is taken
// while it waits, and a following query stalls only at its own end.
// Reset (i_rst_n low, synchronous) idles the controller, empties the result
// register and sets octave_log2 to 5; the table contents are undefined until written.
`default_nettype none

module value_noise_turbulence_top
    import vnt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [0:0]          i_command,
    input  wire logic [COORD_W-1:0]  i_x_coord,
    input  wire logic [COORD_W-1:0]  i_y_coord,
    input  wire logic [ENTRY_W-1:0]  i_entry_row,
    input  wire logic [ENTRY_W-1:0]  i_entry_col,
    input  wire logic [SMP_W-1:0]    i_entry_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OUT_W-1:0]         o_turbulence_value,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    vnt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command[0]),
        .o_ready   (o_ready),
        .o_cmd     (dp_cmd),
        .i_stat    (dp_stat)
    );

    vnt_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_entry_row        (i_entry_row),
        .i_entry_col        (i_entry_col),
        .i_entry_value      (i_entry_value),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_turbulence_value (o_turbulence_value)
    );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the value noise turbulence block, with a table mirror and predictor.
module tb;
    import vnt_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    // The drain length exceeds the longest query, at octave_log2 8.
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1000000;

    // One row of the directed table. Query rows with zfill set load any missing
    // corner with zero; rows with typed set carry their own expected result.
    typedef struct packed {
        t_cmd               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ENTRY_W-1:0] row;
        logic [ENTRY_W-1:0] col;
        logic [SMP_W-1:0]   val;
        bit                 zfill;
        bit                 typed;
        logic [OUT_W-1:0]   res;
    } t_row;

    localparam int N_ROWS = 20;
    localparam t_row DIRECTED [N_ROWS] = '{
        // Zero-filled corners at the origin and at the far corner: nothing to sum.
        '{CMD_QUERY, 24'h000000, 24'h000000, 8'd0,   8'd0,   15'h0000, 1'b1, 1'b1, 16'd0},
        '{CMD_QUERY, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   8'd0,   15'h0000, 1'b1, 1'b1, 16'd0},
        // Full-scale and zero samples on the four wrapped corners.
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd0,   8'd0,   15'h7FFF, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd255, 8'd255, 15'h7FFF, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd0,   8'd255, 15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd255, 8'd0,   15'h7FFF, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h000000, 24'h000000, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'hFFFFFF, 24'h000000, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h000000, 24'hFFFFFF, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        // Overwrite the upper-left neighbor with zero: a zero fraction reads only it.
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd255, 8'd255, 15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h000000, 24'h000000, 8'd0,   8'd0,   15'h0000, 1'b1, 1'b1, 16'd0},
        // Half and nearly-full fractions.
        '{CMD_QUERY, 24'h000080, 24'h000080, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h0000FF, 24'h0000FF, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd128, 8'd127, 15'h5555, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd127, 8'd128, 15'h2AAA, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h808080, 24'h7F7F7F, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h123456, 24'hABCDEF, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0},
        '{CMD_WRITE, 24'h000000, 24'h000000, 8'd1,   8'd1,   15'h0001, 1'b0, 1'b0, 16'd0},
        '{CMD_QUERY, 24'h000180, 24'h000100, 8'd0,   8'd0,   15'h0000, 1'b0, 1'b0, 16'd0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [0:0]         i_command;
    logic [COORD_W-1:0] i_x_coord;
    logic [COORD_W-1:0] i_y_coord;
    logic [ENTRY_W-1:0] i_entry_row;
    logic [ENTRY_W-1:0] i_entry_col;
    logic [SMP_W-1:0]   i_entry_value;
    logic               o_valid;
    logic               i_ready;
    logic [OUT_W-1:0]   o_turbulence_value;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;

    // Mirror of the noise table, with a mark per entry once it has been written.
    logic [SMP_W-1:0]   sample_mem [DEPTH];
    bit                 sample_set [DEPTH];
    logic [ADDR_W-1:0]  written_q [$];
    logic [OUT_W-1:0]   turb_expect_q [$];
    logic [CFG_W-1:0]   oct_cfg = CFG_RESET;

    logic [COORD_W-1:0] anchor_x [2];
    logic [COORD_W-1:0] anchor_y [2];
    int                 burst_left = 0;
    int                 txn_cnt = 0;
    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;
    bit                 hold_req = 1'b0;

    value_noise_turbulence_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_entry_row        (i_entry_row),
        .i_entry_col        (i_entry_col),
        .i_entry_value      (i_entry_value),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_turbulence_value (o_turbulence_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Octave count actually used: register values above the maximum saturate.
    function automatic int oct_eff();
        return (oct_cfg > MAX_OCTAVE_LOG) ? MAX_OCTAVE_LOG : int'(oct_cfg);
    endfunction

    function automatic logic [63:0] sample_at(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        return 64'(sample_mem[{r, c}]);
    endfunction

    // Sum of bilinear octaves, from size 2^k down to 1, scaled back to Q1.15.
    // Each octave blend is kept to Q0.30 before weighting by its size.
    function automatic logic [OUT_W-1:0] turbulence_of(logic [COORD_W-1:0] x,
                                                       logic [COORD_W-1:0] y);
        int               k;
        int               f;
        logic [63:0]      one, fx, fy, p, acc;
        logic [COL_W-1:0] cx, px;
        logic [ROW_W-1:0] cy, py;
        k   = oct_eff();
        acc = '0;
        for (int j = k; j >= 0; j--) begin
            f   = FRAC_BASE + j;
            one = 64'd1 << f;
            fx  = 64'(x) & (one - 64'd1);
            fy  = 64'(y) & (one - 64'd1);
            // Truncating to the index width wraps the cell, and the neighbor wraps below zero.
            cx  = COL_W'(x >> f);
            cy  = ROW_W'(y >> f);
            px  = cx - 1'b1;
            py  = cy - 1'b1;
            p   = fx * fy * sample_at(cy, cx)
                + (one - fx) * fy * sample_at(cy, px)
                + fx * (one - fy) * sample_at(py, cx)
                + (one - fx) * (one - fy) * sample_at(py, px);
            acc += (p >> (2 * j + 1)) << j;
        end
        return OUT_W'(acc >> (SMP_W + k));
    endfunction

    // Mostly random samples, with the two extremes now and then.
    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // Offer one transaction from a falling edge and hold it until accepted.
    // Bursts of random length with random gaps shape the input side.
    task automatic send_txn(input t_cmd cmd, input logic [COORD_W-1:0] x, y,
                            input logic [ENTRY_W-1:0] row, col,
                            input logic [SMP_W-1:0] val,
                            input bit typed, input logic [OUT_W-1:0] typed_res);
        logic [ADDR_W-1:0] addr;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 15);
        end
        i_valid       = 1'b1;
        i_command     = cmd;
        i_x_coord     = x;
        i_y_coord     = y;
        i_entry_row   = row;
        i_entry_col   = col;
        i_entry_value = val;
        do @(posedge i_clk); while (!o_ready);
        // Accepted: advance the mirror in transaction order.
        addr = {row, col};
        if (cmd == CMD_WRITE) begin
            if (!sample_set[addr]) begin
                sample_set[addr] = 1'b1;
                written_q.push_back(addr);
            end
            sample_mem[addr] = val;
        end else begin
            turb_expect_q.push_back(typed ? typed_res : turbulence_of(x, y));
        end
        txn_cnt++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Load every corner the query will read that is still unwritten, then query.
    task automatic run_query(input logic [COORD_W-1:0] x, y, input bit zero_fill,
                             input bit typed, input logic [OUT_W-1:0] typed_res);
        int               f;
        logic [COL_W-1:0] cx, cc;
        logic [ROW_W-1:0] cy, rr;
        for (int j = oct_eff(); j >= 0; j--) begin
            f  = FRAC_BASE + j;
            cx = COL_W'(x >> f);
            cy = ROW_W'(y >> f);
            // Bit 0 of n steps to the left column, bit 1 to the upper row.
            for (int n = 0; n < 4; n++) begin
                rr = cy - ROW_W'(n[1]);
                cc = cx - COL_W'(n[0]);
                if (!sample_set[{rr, cc}])
                    send_txn(CMD_WRITE, '0, '0, rr, cc, zero_fill ? '0 : pick_sample(),
                             1'b0, '0);
            end
        end
        send_txn(CMD_QUERY, x, y, '0, '0, '0, typed, typed_res);
    endtask

    // Drop valid and wait until every query has returned and the block is quiet.
    task automatic drain();
        i_valid    = 1'b0;
        burst_left = 0;
        while (turb_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_octave(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        oct_cfg     = v;
    endtask

    // Random traffic: queries near two anchor points per axis (so the table
    // fills quickly), a few anywhere, overwrites of loaded entries, and writes
    // to random positions.
    task automatic random_phase(input int n_txn, input bit with_hold);
        int                 stop_at;
        int                 pick;
        logic [COORD_W-1:0] x, y;
        logic [ADDR_W-1:0]  addr;
        stop_at     = txn_cnt + n_txn;
        anchor_x[0] = COORD_W'($urandom);
        anchor_y[0] = COORD_W'($urandom);
        hold_req    = with_hold;
        while (txn_cnt < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (pick < 3) begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end else begin
                    // Randomize the fraction and the lowest cell bit around an anchor.
                    x = anchor_x[$urandom_range(0, 1)];
                    y = anchor_y[$urandom_range(0, 1)];
                    x[FRAC_BASE:0] = (FRAC_BASE + 1)'($urandom);
                    y[FRAC_BASE:0] = (FRAC_BASE + 1)'($urandom);
                end
                run_query(x, y, 1'b0, 1'b0, '0);
            end else if (pick < 85) begin
                addr = written_q[$urandom_range(0, written_q.size() - 1)];
                send_txn(CMD_WRITE, '0, '0, addr[ADDR_W-1 -: ROW_W], addr[COL_W-1:0],
                         pick_sample(), 1'b0, '0);
            end else begin
                send_txn(CMD_WRITE, '0, '0, ENTRY_W'($urandom), ENTRY_W'($urandom),
                         pick_sample(), 1'b0, '0);
            end
        end
    endtask

    // Result side: cycle through stall patterns of random length, and on
    // request hold off for a long stretch so the output register fills and
    // the block stalls its input.
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int          idle_cnt;
        i_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                for (idle_cnt = 0; idle_cnt < HOLD_CYCLES; idle_cnt++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0:       i_ready = 1'b1;
                1:       i_ready = ($urandom_range(0, 1) == 0);
                2:       i_ready = ($urandom_range(0, 3) == 0);
                default: i_ready = (mode_left[2:0] != 3'd0);
            endcase
        end
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge i_clk) begin : check_result
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (turb_expect_q.size() == 0) begin
                $error("turbulence_value: no query pending, got %0d", o_turbulence_value);
                fail_cnt++;
            end else begin
                want = turb_expect_q.pop_front();
                if (o_turbulence_value !== want) begin
                    $error("turbulence_value: expected %0d, got %0d", want,
                           o_turbulence_value);
                    fail_cnt++;
                end
            end
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = CMD_WRITE;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_entry_row   = '0;
        i_entry_col   = '0;
        i_entry_value = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = CFG_RESET;
        anchor_x[1]   = COORD_W'($urandom);
        anchor_y[1]   = COORD_W'($urandom);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset octave count.
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].cmd == CMD_WRITE)
                send_txn(CMD_WRITE, '0, '0, DIRECTED[i].row, DIRECTED[i].col,
                         DIRECTED[i].val, 1'b0, '0);
            else
                run_query(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].zfill,
                          DIRECTED[i].typed, DIRECTED[i].res);
        end

        // Random phases over several octave settings: a single octave, the
        // deepest, the largest register value and one just past the maximum
        // (both saturate), a middle one, and a random one.
        write_octave(4'd0);
        random_phase(250, 1'b0);
        write_octave(CFG_W'(MAX_OCTAVE_LOG));
        random_phase(300, 1'b1);
        write_octave('1);
        random_phase(250, 1'b0);
        write_octave(4'd3);
        random_phase(250, 1'b1);
        write_octave(CFG_W'(MAX_OCTAVE_LOG + 1));
        random_phase(300, 1'b0);
        write_octave(CFG_W'($urandom_range(0, 15)));
        random_phase(250, 1'b0);

        drain();
        if (fail_cnt == 0 && turb_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
rtl/vnt_pkg.sv
rtl/vnt_dpath.sv
rtl/vnt_ctrl.sv
rtl/value_noise_turbulence_top.sv
tb/tb.sv
